// ===== src/ciwg_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, widths and register indexes for the corner interest block
package ciwg_pkg;

  // geometry
  localparam int WINDOW     = 5;
  localparam int CELL       = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int CELL_DIM   = 128;

  // field widths
  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 11;
  localparam int RTHR_W  = 17;
  localparam int WTHR_W  = 24;
  localparam int CFG_D_W = 24;
  localparam int CFG_I_W = 2;
  localparam int COORD_W = 10;
  localparam int CIDX_W  = 7;

  // internal widths
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TAP_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SQ_W    = 2 * PIX_W;
  localparam int UV_W    = SQ_W + 1;
  localparam int CS_SQ_W = $clog2(WINDOW * 65025 + 1);
  localparam int CS_UV_W = CS_SQ_W + 1;
  localparam int WS_SQ_W = $clog2(WINDOW * WINDOW * 65025 + 1);
  localparam int WS_UV_W = WS_SQ_W + 1;
  localparam int TRACE_W = WS_SQ_W + 1;
  localparam int DET_W   = 2 * WS_SQ_W;
  localparam int D2_W    = 2 * TRACE_W;
  localparam int NUM_W   = DET_W + 4;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int QSTEPS  = 18;
  localparam int QV_W    = 17;
  localparam int QQ_W    = 18;
  localparam int WV_W    = 24;
  localparam int CELL_A_W = 2 * CIDX_W;

  localparam logic [QV_W-1:0] Q_ONE = 17'h10000;

  // product and column-sum entries
  typedef struct packed {
    logic [SQ_W-1:0]        uu;
    logic [SQ_W-1:0]        vv;
    logic signed [UV_W-1:0] uv;
  } prod_t;

  typedef struct packed {
    logic [CS_SQ_W-1:0]        uu;
    logic [CS_SQ_W-1:0]        vv;
    logic signed [CS_UV_W-1:0] uv;
  } csum_t;

  typedef struct packed {
    logic [QV_W-1:0] q;
    logic [WV_W-1:0] w;
  } cellmax_t;

  // configuration register indexes
  typedef enum logic [CFG_I_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RTHR   = 2'd2,
    REG_WTHR   = 2'd3
  } cfg_reg_t;

endpackage

// ===== src/corner_interest_window_grid.sv =====
`timescale 1ns / 1ps
// corner interest operator over a raster image with per-cell maxima
//
//  channel | direction | ports
//  in      | request   | in_valid, in_ready, in_pixel
//  out     | result    | out_valid, out_ready, out_center_row .. out_cell_col
//  cfg     | write     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// the pace of a pixel that completes no window is set by the single port
// of the previous-row line memory (two reads, two writes)
// the pace of a pixel that completes a window is set by the
// bit-serial divider (46 steps) behind the window sums
// after reset a clearing pass zeroes all 16384 entries of the cell maxima store
// a full output register stalls the block in its final step
module corner_interest_window_grid (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ciwg_pkg::PIX_W-1:0]    in_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ciwg_pkg::COORD_W-1:0]  out_center_row,
  output logic [ciwg_pkg::COORD_W-1:0]  out_center_col,
  output logic [ciwg_pkg::WV_W-1:0]     out_interest_weight,
  output logic [ciwg_pkg::QV_W-1:0]     out_roundness,
  output logic                          out_passes_thresholds,
  output logic                          out_new_cell_best,
  output logic [ciwg_pkg::CIDX_W-1:0]   out_cell_row,
  output logic [ciwg_pkg::CIDX_W-1:0]   out_cell_col,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ciwg_pkg::CFG_I_W-1:0]  cfg_index,
  input  logic [ciwg_pkg::CFG_D_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD0, S_RD1, S_CALC, S_WR2,
    S_SUM, S_MUL, S_DET, S_DIV, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [ciwg_pkg::SIZE_W-1:0] width_r, height_r;
  logic [ciwg_pkg::RTHR_W-1:0] rthr_r;
  logic [ciwg_pkg::WTHR_W-1:0] wthr_r;

  // position and pixel context
  logic [ciwg_pkg::PIX_W-1:0]  pix_r, left_r, pa_r;
  logic [ciwg_pkg::ROW_W-1:0]  row_r;
  logic [ciwg_pkg::COL_W-1:0]  col_r;
  logic [ciwg_pkg::SLOT_W-1:0] rslot_r;
  logic [ciwg_pkg::CELL_A_W-1:0] clr_r;

  // window context
  logic [ciwg_pkg::ROW_W-1:0]  j_r;
  logic [ciwg_pkg::COL_W-1:0]  i_r;
  ciwg_pkg::csum_t             tap_r [ciwg_pkg::WINDOW];
  logic [ciwg_pkg::WS_SQ_W-1:0] suu_r, svv_r;
  logic signed [ciwg_pkg::WS_UV_W-1:0] suv_r;
  logic [ciwg_pkg::TRACE_W-1:0] trace_r;
  logic [ciwg_pkg::DET_W-1:0]   a_r, b_r, det_r;
  logic [ciwg_pkg::D2_W-1:0]    d2_r;
  logic                          qsat_r;
  ciwg_pkg::cellmax_t            cmax_r;

  // divider state
  logic [ciwg_pkg::CNT_W-1:0]   cnt_r;
  logic [ciwg_pkg::NUM_W-1:0]   numsh_r, wquo_r;
  logic [ciwg_pkg::TRACE_W-1:0] wrem_r;
  logic [ciwg_pkg::D2_W-1:0]    qrem_r;
  logic [ciwg_pkg::QQ_W-1:0]    qq_r;

  // output register
  logic                          out_valid_r;
  logic [ciwg_pkg::COORD_W-1:0]  o_crow_r, o_ccol_r;
  logic [ciwg_pkg::WV_W-1:0]     o_w_r;
  logic [ciwg_pkg::QV_W-1:0]     o_q_r;
  logic                          o_pass_r, o_best_r;
  logic [ciwg_pkg::CIDX_W-1:0]   o_cr_r, o_cc_r;

  // memories
  logic [ciwg_pkg::PIX_W-1:0] prev_mem [ciwg_pkg::MAX_WIDTH];
  ciwg_pkg::prod_t  prod_mem [ciwg_pkg::WINDOW][ciwg_pkg::MAX_WIDTH];
  ciwg_pkg::csum_t  cs_mem   [ciwg_pkg::MAX_WIDTH];
  ciwg_pkg::cellmax_t cell_mem [ciwg_pkg::CELL_DIM * ciwg_pkg::CELL_DIM];

  logic [ciwg_pkg::PIX_W-1:0]  prev_q_r, prev_wdata;
  logic [ciwg_pkg::COL_W-1:0]  prev_addr;
  logic                        prev_we;
  ciwg_pkg::prod_t             prod_q_r, prod_new;
  ciwg_pkg::csum_t             cs_q_r, cs_new;
  logic                        calc_we;
  ciwg_pkg::cellmax_t          cell_q_r, cell_wdata;
  logic [ciwg_pkg::CELL_A_W-1:0] cell_addr, cidx;
  logic                        cell_we;

  // combinational helpers
  logic [ciwg_pkg::COL_W-1:0]  col_idx;
  logic [ciwg_pkg::SLOT_W-1:0] slot;
  logic [ciwg_pkg::SIZE_W-1:0] w_eff, h_eff;
  logic                        last_col, emit, act, load;
  logic [ciwg_pkg::SIZE_W-1:0] col_inc, row_inc;
  logic signed [ciwg_pkg::PIX_W:0] gu, gv;
  logic signed [2*ciwg_pkg::PIX_W+1:0] puu, pvv, puv;
  logic [ciwg_pkg::WS_SQ_W-1:0] sum_uu, sum_vv;
  logic signed [ciwg_pkg::WS_UV_W-1:0] sum_uv;
  logic [ciwg_pkg::WS_SQ_W-1:0] suv_mag;
  logic [ciwg_pkg::DET_W-1:0]   det_c;
  logic [ciwg_pkg::TRACE_W:0]   wsh;
  logic [ciwg_pkg::D2_W:0]      qsh;
  logic                          tz;
  logic [ciwg_pkg::WV_W-1:0]    wv;
  logic [ciwg_pkg::QV_W-1:0]    qv;
  logic                          pass, best;
  logic [ciwg_pkg::ROW_W-1:0]   crow_full;
  logic [ciwg_pkg::COL_W-1:0]   ccol_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  // effective image size
  always_comb begin
    if (width_r < ciwg_pkg::SIZE_W'(2)) w_eff = ciwg_pkg::SIZE_W'(2);
    else if (width_r > ciwg_pkg::SIZE_W'(ciwg_pkg::MAX_WIDTH))
      w_eff = ciwg_pkg::SIZE_W'(ciwg_pkg::MAX_WIDTH);
    else w_eff = width_r;
    if (height_r < ciwg_pkg::SIZE_W'(2)) h_eff = ciwg_pkg::SIZE_W'(2);
    else if (height_r > ciwg_pkg::SIZE_W'(ciwg_pkg::MAX_HEIGHT))
      h_eff = ciwg_pkg::SIZE_W'(ciwg_pkg::MAX_HEIGHT);
    else h_eff = height_r;
  end

  // position decode
  assign col_idx  = col_r - ciwg_pkg::COL_W'(1);
  assign slot     = (rslot_r == '0) ? ciwg_pkg::SLOT_W'(ciwg_pkg::WINDOW - 1)
                                    : rslot_r - ciwg_pkg::SLOT_W'(1);
  assign col_inc  = ciwg_pkg::SIZE_W'(col_r) + ciwg_pkg::SIZE_W'(1);
  assign row_inc  = ciwg_pkg::SIZE_W'(row_r) + ciwg_pkg::SIZE_W'(1);
  assign last_col = (col_inc >= w_eff);
  assign act      = (row_r != '0) && (col_r != '0);
  assign emit     = (row_r >= ciwg_pkg::ROW_W'(ciwg_pkg::WINDOW)) &&
                    (col_r >= ciwg_pkg::COL_W'(ciwg_pkg::WINDOW)) &&
                    (ciwg_pkg::SIZE_W'(row_r) < h_eff) &&
                    (ciwg_pkg::SIZE_W'(col_r) < w_eff);

  // roberts gradients and column-sum update
  always_comb begin
    gu  = $signed({1'b0, pix_r}) - $signed({1'b0, pa_r});
    gv  = $signed({1'b0, prev_q_r}) - $signed({1'b0, left_r});
    puu = gu * gu;
    pvv = gv * gv;
    puv = gu * gv;
    prod_new.uu = puu[ciwg_pkg::SQ_W-1:0];
    prod_new.vv = pvv[ciwg_pkg::SQ_W-1:0];
    prod_new.uv = puv[ciwg_pkg::UV_W-1:0];
    if (row_r == ciwg_pkg::ROW_W'(1)) begin
      cs_new.uu = ciwg_pkg::CS_SQ_W'(prod_new.uu);
      cs_new.vv = ciwg_pkg::CS_SQ_W'(prod_new.vv);
      cs_new.uv = ciwg_pkg::CS_UV_W'(prod_new.uv);
    end else if (row_r <= ciwg_pkg::ROW_W'(ciwg_pkg::WINDOW)) begin
      cs_new.uu = cs_q_r.uu + ciwg_pkg::CS_SQ_W'(prod_new.uu);
      cs_new.vv = cs_q_r.vv + ciwg_pkg::CS_SQ_W'(prod_new.vv);
      cs_new.uv = cs_q_r.uv + ciwg_pkg::CS_UV_W'(prod_new.uv);
    end else begin
      cs_new.uu = cs_q_r.uu + ciwg_pkg::CS_SQ_W'(prod_new.uu)
                - ciwg_pkg::CS_SQ_W'(prod_q_r.uu);
      cs_new.vv = cs_q_r.vv + ciwg_pkg::CS_SQ_W'(prod_new.vv)
                - ciwg_pkg::CS_SQ_W'(prod_q_r.vv);
      cs_new.uv = cs_q_r.uv + ciwg_pkg::CS_UV_W'(prod_new.uv)
                - ciwg_pkg::CS_UV_W'(prod_q_r.uv);
    end
    calc_we = (state_r == S_CALC) && act;
  end

  // window sums over the column-sum taps
  always_comb begin
    sum_uu = '0;
    sum_vv = '0;
    sum_uv = '0;
    for (int t = 0; t < ciwg_pkg::WINDOW; t++) begin
      sum_uu = sum_uu + ciwg_pkg::WS_SQ_W'(tap_r[t].uu);
      sum_vv = sum_vv + ciwg_pkg::WS_SQ_W'(tap_r[t].vv);
      sum_uv = sum_uv + ciwg_pkg::WS_UV_W'(tap_r[t].uv);
    end
  end

  // determinant, divider steps and final result
  always_comb begin
    suv_mag = (suv_r < 0) ? ciwg_pkg::WS_SQ_W'(-suv_r) : ciwg_pkg::WS_SQ_W'(suv_r);
    det_c   = (a_r > b_r) ? a_r - b_r : '0;
    wsh     = {wrem_r, numsh_r[ciwg_pkg::NUM_W-1]};
    qsh     = {qrem_r, 1'b0};
    tz      = (trace_r == '0);
    if (tz) wv = '0;
    else if (|wquo_r[ciwg_pkg::NUM_W-1:ciwg_pkg::WV_W]) wv = '1;
    else wv = wquo_r[ciwg_pkg::WV_W-1:0];
    if (tz) qv = '0;
    else if (qsat_r) qv = ciwg_pkg::Q_ONE;
    else if (qq_r > ciwg_pkg::QQ_W'(ciwg_pkg::Q_ONE)) qv = ciwg_pkg::Q_ONE;
    else qv = qq_r[ciwg_pkg::QV_W-1:0];
    pass = (qv > rthr_r) && (wv > wthr_r);
    best = pass && (qv > cmax_r.q) && (wv > cmax_r.w);
    load = (state_r == S_FIN) && (!out_valid_r || out_ready);
    crow_full = j_r / ciwg_pkg::ROW_W'(ciwg_pkg::CELL);
    ccol_full = i_r / ciwg_pkg::COL_W'(ciwg_pkg::CELL);
    cidx = {crow_full[ciwg_pkg::CIDX_W-1:0], ccol_full[ciwg_pkg::CIDX_W-1:0]};
  end

  // line memory port control
  always_comb begin
    prev_we    = 1'b0;
    prev_wdata = left_r;
    unique case (state_r)
      S_RD0: prev_addr = col_idx;
      S_CALC: begin
        prev_addr = col_idx;
        prev_we   = (col_r != '0);
      end
      S_WR2: begin
        prev_addr  = col_r;
        prev_we    = last_col;
        prev_wdata = pix_r;
      end
      default: prev_addr = col_r;
    endcase
  end

  // cell store port control
  always_comb begin
    cell_we    = 1'b0;
    cell_addr  = cidx;
    cell_wdata = '{q: qv, w: wv};
    if (state_r == S_CLR) begin
      cell_we    = 1'b1;
      cell_addr  = clr_r;
      cell_wdata = '0;
    end else if (load && best) begin
      cell_we = 1'b1;
    end
  end

  // previous pixel row memory
  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_addr] <= prev_wdata;
    prev_q_r <= prev_mem[prev_addr];
  end

  // product ring and column sums memories
  always_ff @(posedge clk) begin
    if (calc_we) begin
      prod_mem[slot][col_idx] <= prod_new;
      cs_mem[col_idx]         <= cs_new;
    end
    prod_q_r <= prod_mem[slot][col_idx];
    cs_q_r   <= cs_mem[col_idx];
  end

  // cell maxima memory
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_addr] <= cell_wdata;
    cell_q_r <= cell_mem[cell_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ciwg_pkg::SIZE_W'(1024);
      height_r <= ciwg_pkg::SIZE_W'(1024);
      rthr_r   <= ciwg_pkg::RTHR_W'(32768);
      wthr_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ciwg_pkg::cfg_reg_t'(cfg_index))
        ciwg_pkg::REG_WIDTH:  width_r  <= cfg_data[ciwg_pkg::SIZE_W-1:0];
        ciwg_pkg::REG_HEIGHT: height_r <= cfg_data[ciwg_pkg::SIZE_W-1:0];
        ciwg_pkg::REG_RTHR:   rthr_r   <= cfg_data[ciwg_pkg::RTHR_W-1:0];
        ciwg_pkg::REG_WTHR:   wthr_r   <= cfg_data[ciwg_pkg::WTHR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer with datapath and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      rslot_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output valid: set by a load, cleared once taken
      if (load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + ciwg_pkg::CELL_A_W'(1);
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            pix_r   <= in_pixel;
            state_r <= S_RD0;
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          pa_r    <= prev_q_r;
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (act) begin
            tap_r[0] <= cs_new;
            for (int t = 1; t < ciwg_pkg::WINDOW; t++) tap_r[t] <= tap_r[t-1];
          end
          state_r <= S_WR2;
        end
        S_WR2: begin
          left_r <= pix_r;
          j_r    <= row_r - ciwg_pkg::ROW_W'(ciwg_pkg::WINDOW);
          i_r    <= col_r - ciwg_pkg::COL_W'(ciwg_pkg::WINDOW);
          if (last_col) begin
            col_r <= '0;
            if (row_inc >= h_eff) begin
              row_r   <= '0;
              rslot_r <= '0;
            end else begin
              row_r   <= row_inc[ciwg_pkg::ROW_W-1:0];
              rslot_r <= (rslot_r == ciwg_pkg::SLOT_W'(ciwg_pkg::WINDOW - 1))
                         ? '0 : rslot_r + ciwg_pkg::SLOT_W'(1);
            end
          end else begin
            col_r <= col_inc[ciwg_pkg::COL_W-1:0];
          end
          state_r <= emit ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          suu_r   <= sum_uu;
          svv_r   <= sum_vv;
          suv_r   <= sum_uv;
          trace_r <= ciwg_pkg::TRACE_W'(sum_uu) + ciwg_pkg::TRACE_W'(sum_vv);
          state_r <= S_MUL;
        end
        S_MUL: begin
          a_r     <= suu_r * svv_r;
          b_r     <= suv_mag * suv_mag;
          d2_r    <= trace_r * trace_r;
          state_r <= S_DET;
        end
        S_DET: begin
          det_r   <= det_c;
          cmax_r  <= cell_q_r;
          qsat_r  <= (ciwg_pkg::D2_W'(det_c) >= d2_r);
          numsh_r <= {det_c, 4'b0000};
          wquo_r  <= '0;
          wrem_r  <= '0;
          qrem_r  <= ciwg_pkg::D2_W'(det_c);
          qq_r    <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          numsh_r <= numsh_r << 1;
          if (wsh >= {1'b0, trace_r}) begin
            wrem_r <= ciwg_pkg::TRACE_W'(wsh - {1'b0, trace_r});
            wquo_r <= {wquo_r[ciwg_pkg::NUM_W-2:0], 1'b1};
          end else begin
            wrem_r <= wsh[ciwg_pkg::TRACE_W-1:0];
            wquo_r <= {wquo_r[ciwg_pkg::NUM_W-2:0], 1'b0};
          end
          if (cnt_r < ciwg_pkg::CNT_W'(ciwg_pkg::QSTEPS)) begin
            if (qsh >= {1'b0, d2_r}) begin
              qrem_r <= ciwg_pkg::D2_W'(qsh - {1'b0, d2_r});
              qq_r   <= {qq_r[ciwg_pkg::QQ_W-2:0], 1'b1};
            end else begin
              qrem_r <= qsh[ciwg_pkg::D2_W-1:0];
              qq_r   <= {qq_r[ciwg_pkg::QQ_W-2:0], 1'b0};
            end
          end
          cnt_r <= cnt_r + ciwg_pkg::CNT_W'(1);
          if (cnt_r == ciwg_pkg::CNT_W'(ciwg_pkg::NUM_W - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (load) begin
            o_crow_r    <= ciwg_pkg::COORD_W'(j_r + ciwg_pkg::ROW_W'(ciwg_pkg::WINDOW / 2));
            o_ccol_r    <= ciwg_pkg::COORD_W'(i_r + ciwg_pkg::COL_W'(ciwg_pkg::WINDOW / 2));
            o_w_r       <= wv;
            o_q_r       <= qv;
            o_pass_r    <= pass;
            o_best_r    <= best;
            o_cr_r      <= cidx[ciwg_pkg::CELL_A_W-1:ciwg_pkg::CIDX_W];
            o_cc_r      <= cidx[ciwg_pkg::CIDX_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_center_row        = o_crow_r;
  assign out_center_col        = o_ccol_r;
  assign out_interest_weight   = o_w_r;
  assign out_roundness         = o_q_r;
  assign out_passes_thresholds = o_pass_r;
  assign out_new_cell_best     = o_best_r;
  assign out_cell_row          = o_cr_r;
  assign out_cell_col          = o_cc_r;

  // no result while the cell store is being cleared
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !out_valid_r)
    else $error("result during clearing pass");

  // a new result only comes from the final step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside final step");

  // determinant never exceeds the diagonal product
  a_det_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (det_r <= a_r))
    else $error("determinant out of range");

  // roundness stays within one
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (qv <= ciwg_pkg::Q_ONE))
    else $error("roundness above one");

  // a cell best is always a threshold pass
  a_best_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_best_r) |-> o_pass_r)
    else $error("cell best without threshold pass");

endmodule
